>>> src/mp2d_pkg.sv
// Shared types and constants for the 2-D max pooling block.
package mp2d_pkg;

   localparam int MAX_KERNEL_DEF  = 8;
   localparam int MAX_WIDTH_DEF   = 1024;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam int K_BITS      = 4;
   localparam int DIM_BITS    = 11;
   localparam int PLANE_BITS  = 9;
   localparam int CH_BITS     = 8;
   localparam int POS_BITS    = 10;
   localparam int IDX_BITS    = 3;
   localparam int DATA_BITS   = 11;
   localparam int PLANE_LIMIT = 256;

   localparam logic [IDX_BITS-1:0] REG_KERNEL_ROWS = 3'd0;
   localparam logic [IDX_BITS-1:0] REG_KERNEL_COLS = 3'd1;
   localparam logic [IDX_BITS-1:0] REG_STEP        = 3'd2;
   localparam logic [IDX_BITS-1:0] REG_IN_ROWS     = 3'd3;
   localparam logic [IDX_BITS-1:0] REG_IN_COLS     = 3'd4;
   localparam logic [IDX_BITS-1:0] REG_PLANE_COUNT = 3'd5;

   localparam logic [K_BITS-1:0]     RST_KERNEL = 4'd2;
   localparam logic [K_BITS-1:0]     RST_STEP   = 4'd2;
   localparam logic [DIM_BITS-1:0]   RST_DIM    = 11'd28;
   localparam logic [PLANE_BITS-1:0] RST_PLANES = 9'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_LAST,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic take;
      logic rd_step;
      logic load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic hit;
      logic rd_done;
      logic out_free;
   } ctrl_stat_type;

endpackage

>>> src/mp2d_ctrl.sv
// Controller: sequences sample intake, window reads and result hand-off.
module mp2d_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  mp2d_pkg::ctrl_stat_type stat,
   output mp2d_pkg::ctrl_cmd_type  cmd
);

   mp2d_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mp2d_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mp2d_pkg::ST_IDLE: begin
            if (req_valid && stat.hit) state_in = mp2d_pkg::ST_READ;
         end
         mp2d_pkg::ST_READ: begin
            if (stat.rd_done) state_in = mp2d_pkg::ST_LAST;
         end
         mp2d_pkg::ST_LAST: begin
            state_in = mp2d_pkg::ST_EMIT;
         end
         mp2d_pkg::ST_EMIT: begin
            if (stat.out_free) state_in = mp2d_pkg::ST_IDLE;
         end
         default: state_in = mp2d_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd.take     = 1'b0;
      cmd.rd_step  = 1'b0;
      cmd.load_out = 1'b0;
      unique case (state_ff)
         mp2d_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
         end
         mp2d_pkg::ST_READ: cmd.rd_step = 1'b1;
         mp2d_pkg::ST_LAST: cmd.rd_step = 1'b0;
         mp2d_pkg::ST_EMIT: cmd.load_out = stat.out_free;
         default: req_ready = 1'b0;
      endcase
   end

endmodule

>>> src/mp2d_dp.sv
// Datapath: settings, position counters, line store, window maximum and result register.
module mp2d_dp #(
   parameter int MAX_KERNEL  = mp2d_pkg::MAX_KERNEL_DEF,
   parameter int MAX_WIDTH   = mp2d_pkg::MAX_WIDTH_DEF,
   parameter int SAMPLE_BITS = mp2d_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [mp2d_pkg::IDX_BITS-1:0]       csr_index,
   input  logic [mp2d_pkg::DATA_BITS-1:0]      csr_data,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_value,
   input  mp2d_pkg::ctrl_cmd_type              cmd,
   output mp2d_pkg::ctrl_stat_type             stat,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic signed [SAMPLE_BITS-1:0]       rsp_peak,
   output logic [mp2d_pkg::CH_BITS-1:0]        rsp_out_channel,
   output logic [mp2d_pkg::POS_BITS-1:0]       rsp_out_row,
   output logic [mp2d_pkg::POS_BITS-1:0]       rsp_out_col,
   output logic                                rsp_last_of_tensor
);

   localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int SW   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
   localparam int CMPW = ((CW > mp2d_pkg::DIM_BITS) ? CW : mp2d_pkg::DIM_BITS) + 2;
   localparam int SLW  = ((SW > mp2d_pkg::K_BITS) ? SW : mp2d_pkg::K_BITS) + 2;
   localparam int KB   = mp2d_pkg::K_BITS;

   logic [KB-1:0]                    kr_ff, kc_ff, step_ff;
   logic [mp2d_pkg::DIM_BITS-1:0]    rows_ff, cols_ff;
   logic [mp2d_pkg::PLANE_BITS-1:0]  planes_ff;

   logic [CW-1:0]                    col_ff, row_ff, ocol_ff, orow_ff;
   logic [mp2d_pkg::CH_BITS-1:0]     ch_ff;
   logic [SW-1:0]                    slot_ff;
   logic [KB-1:0]                    cph_ff, rph_ff;

   logic [CW-1:0]                    col_in, row_in, ocol_in, orow_in;
   logic [mp2d_pkg::CH_BITS-1:0]     ch_in;
   logic [SW-1:0]                    slot_in;
   logic [KB-1:0]                    cph_in, rph_in;

   logic signed [SAMPLE_BITS-1:0]    store_ff [MAX_KERNEL][MAX_WIDTH];

   logic [SW-1:0]                    rslot_ff, slot0;
   logic [CW-1:0]                    rcol_ff, c0_ff, c0;
   logic [KB-1:0]                    ri_ff, rj_ff;
   logic                             rd_valid_ff, first_ff;
   logic signed [SAMPLE_BITS-1:0]    rd_data_ff, best_ff;

   logic [mp2d_pkg::CH_BITS-1:0]     res_ch_ff;
   logic [CW-1:0]                    res_orow_ff, res_ocol_ff;
   logic                             res_last_ff;

   logic                             rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0]    out_max_ff;
   logic [mp2d_pkg::CH_BITS-1:0]     out_ch_ff;
   logic [mp2d_pkg::POS_BITS-1:0]    out_row_ff, out_col_ff;
   logic                             out_last_ff;

   logic                             cfg_ok, col_ok, row_ok, hit, last;
   logic                             col_end, row_end, ch_end, restart, step_take;
   logic [KB-1:0]                    cph_now;
   logic [CW-1:0]                    ocol_now;
   logic [CMPW-1:0]                  col_x, row_x, ch_x, kr_x, kc_x, st_x;
   logic [SLW-1:0]                   slot_x, km1_x;

   always_comb begin
      cfg_ok = (kr_ff != '0) && (CMPW'(kr_ff) <= CMPW'(MAX_KERNEL))
            && (kc_ff != '0) && (CMPW'(kc_ff) <= CMPW'(MAX_KERNEL))
            && (step_ff != '0) && (CMPW'(step_ff) <= CMPW'(MAX_KERNEL))
            && (rows_ff != '0) && (CMPW'(rows_ff) <= CMPW'(MAX_WIDTH))
            && (cols_ff != '0) && (CMPW'(cols_ff) <= CMPW'(MAX_WIDTH))
            && (planes_ff != '0)
            && (CMPW'(planes_ff) <= CMPW'(mp2d_pkg::PLANE_LIMIT))
            && (CMPW'(kr_ff) <= CMPW'(rows_ff)) && (CMPW'(kc_ff) <= CMPW'(cols_ff));

      col_x = CMPW'(col_ff);
      row_x = CMPW'(row_ff);
      ch_x  = CMPW'(ch_ff);
      kr_x  = CMPW'(kr_ff);
      kc_x  = CMPW'(kc_ff);
      st_x  = CMPW'(step_ff);

      col_ok = (col_x + CMPW'(1)) >= kc_x;
      row_ok = (row_x + CMPW'(1)) >= kr_x;

      if ((col_x + CMPW'(1)) == kc_x) begin
         cph_now  = '0;
         ocol_now = '0;
      end else if ((cph_ff + KB'(1)) == step_ff) begin
         cph_now  = '0;
         ocol_now = ocol_ff + CW'(1);
      end else begin
         cph_now  = cph_ff + KB'(1);
         ocol_now = ocol_ff;
      end

      hit  = cfg_ok && col_ok && row_ok && (cph_now == '0) && (rph_ff == '0);
      last = ((ch_x + CMPW'(1)) == CMPW'(planes_ff))
          && ((row_x + st_x) >= CMPW'(rows_ff))
          && ((col_x + st_x) >= CMPW'(cols_ff));

      c0     = CW'(col_x + CMPW'(1) - kc_x);
      slot_x = SLW'(slot_ff);
      km1_x  = SLW'(kr_ff) - SLW'(1);
      if (slot_x >= km1_x) begin
         slot0 = SW'(slot_x - km1_x);
      end else begin
         slot0 = SW'(slot_x + SLW'(MAX_KERNEL) - km1_x);
      end

      col_end = (col_x + CMPW'(1)) >= CMPW'(cols_ff);
      row_end = (row_x + CMPW'(1)) >= CMPW'(rows_ff);
      ch_end  = (ch_x + CMPW'(1)) >= CMPW'(planes_ff);

      col_in  = col_ff + CW'(1);
      row_in  = row_ff;
      ch_in   = ch_ff;
      slot_in = slot_ff;
      cph_in  = cph_now;
      ocol_in = ocol_now;
      rph_in  = rph_ff;
      orow_in = orow_ff;
      if (col_end) begin
         col_in = '0;
         if (row_end) begin
            row_in  = '0;
            slot_in = '0;
            rph_in  = '0;
            orow_in = '0;
            ch_in   = ch_end ? '0 : ch_ff + mp2d_pkg::CH_BITS'(1);
         end else begin
            row_in  = row_ff + CW'(1);
            slot_in = ((SLW'(slot_ff) + SLW'(1)) == SLW'(MAX_KERNEL)) ? '0
                    : slot_ff + SW'(1);
            if ((row_x + CMPW'(2)) <= kr_x) begin
               rph_in  = '0;
               orow_in = '0;
            end else if ((rph_ff + KB'(1)) == step_ff) begin
               rph_in  = '0;
               orow_in = orow_ff + CW'(1);
            end else begin
               rph_in  = rph_ff + KB'(1);
               orow_in = orow_ff;
            end
         end
      end

      restart   = csr_valid && (csr_index <= mp2d_pkg::REG_PLANE_COUNT);
      step_take = cmd.take && cfg_ok;

      stat.hit      = hit;
      stat.rd_done  = (ri_ff == kr_ff - KB'(1)) && (rj_ff == kc_ff - KB'(1));
      stat.out_free = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kr_ff     <= mp2d_pkg::RST_KERNEL;
         kc_ff     <= mp2d_pkg::RST_KERNEL;
         step_ff   <= mp2d_pkg::RST_STEP;
         rows_ff   <= mp2d_pkg::RST_DIM;
         cols_ff   <= mp2d_pkg::RST_DIM;
         planes_ff <= mp2d_pkg::RST_PLANES;
      end else if (csr_valid) begin
         unique case (csr_index)
            mp2d_pkg::REG_KERNEL_ROWS: kr_ff     <= csr_data[KB-1:0];
            mp2d_pkg::REG_KERNEL_COLS: kc_ff     <= csr_data[KB-1:0];
            mp2d_pkg::REG_STEP:        step_ff   <= csr_data[KB-1:0];
            mp2d_pkg::REG_IN_ROWS:     rows_ff   <= csr_data[mp2d_pkg::DIM_BITS-1:0];
            mp2d_pkg::REG_IN_COLS:     cols_ff   <= csr_data[mp2d_pkg::DIM_BITS-1:0];
            mp2d_pkg::REG_PLANE_COUNT: planes_ff <= csr_data[mp2d_pkg::PLANE_BITS-1:0];
            default: kr_ff <= kr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_ff  <= '0;
         row_ff  <= '0;
         ch_ff   <= '0;
         slot_ff <= '0;
         cph_ff  <= '0;
         rph_ff  <= '0;
         ocol_ff <= '0;
         orow_ff <= '0;
      end else if (step_take) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         ch_ff   <= ch_in;
         slot_ff <= slot_in;
         cph_ff  <= cph_in;
         rph_ff  <= rph_in;
         ocol_ff <= ocol_in;
         orow_ff <= orow_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_take) begin
         store_ff[slot_ff][col_ff] <= req_sample_value;
      end
      if (cmd.rd_step) begin
         rd_data_ff <= store_ff[rslot_ff][rcol_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (step_take) begin
         rslot_ff    <= slot0;
         rcol_ff     <= c0;
         c0_ff       <= c0;
         ri_ff       <= '0;
         rj_ff       <= '0;
         res_ch_ff   <= ch_ff;
         res_orow_ff <= orow_ff;
         res_ocol_ff <= ocol_now;
         res_last_ff <= last;
      end else if (cmd.rd_step) begin
         if ((rj_ff + KB'(1)) == kc_ff) begin
            rj_ff    <= '0;
            rcol_ff  <= c0_ff;
            ri_ff    <= ri_ff + KB'(1);
            rslot_ff <= ((SLW'(rslot_ff) + SLW'(1)) == SLW'(MAX_KERNEL)) ? '0
                      : rslot_ff + SW'(1);
         end else begin
            rj_ff   <= rj_ff + KB'(1);
            rcol_ff <= rcol_ff + CW'(1);
         end
      end
      if (rd_valid_ff) begin
         if (first_ff || (rd_data_ff > best_ff)) best_ff <= rd_data_ff;
      end
      first_ff <= cmd.rd_step && (ri_ff == '0) && (rj_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.rd_step;
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_max_ff  <= best_ff;
         out_ch_ff   <= res_ch_ff;
         out_row_ff  <= mp2d_pkg::POS_BITS'(res_orow_ff);
         out_col_ff  <= mp2d_pkg::POS_BITS'(res_ocol_ff);
         out_last_ff <= res_last_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_peak           = out_max_ff;
   assign rsp_out_channel    = out_ch_ff;
   assign rsp_out_row        = out_row_ff;
   assign rsp_out_col        = out_col_ff;
   assign rsp_last_of_tensor = out_last_ff;

endmodule

>>> src/max_pool_2d.sv
// Top level of the streaming 2-D max pooling block.
// Usage: samples of a 3-D tensor enter on the req_ channel, one word per handshake,
// channel-major, then row, then column. Window maxima leave on the rsp_ channel with
// their output channel, row, column and a flag on the final result of the tensor.
// Settings are written on the csr_ channel (always ready) while the block is idle;
// any write of a known register restarts the tensor at channel 0, row 0, column 0.
// After a sample that completes no stride-aligned window the block is ready for the
// next. After a sample that completes one, the window is read from the single-port
// line store one entry per cycle, then reduced and registered; no sample is taken
// meanwhile. rsp_valid rises when the result enters the free output register.
// The output register holds a result
// while the receiver stalls; new samples are still taken until the next window needs
// the output register, and then the block waits. With invalid settings samples are
// taken and dropped. Reset loads the default settings (2x2 kernel, step 2, 28x28,
// one channel), clears the counters and empties the output register. The line store
// needs no clearing: every entry a window reads was written earlier in that channel.
module max_pool_2d #(
   parameter int MAX_KERNEL  = mp2d_pkg::MAX_KERNEL_DEF,
   parameter int MAX_WIDTH   = mp2d_pkg::MAX_WIDTH_DEF,
   parameter int SAMPLE_BITS = mp2d_pkg::SAMPLE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mp2d_pkg::IDX_BITS-1:0]   csr_index,
   input  logic [mp2d_pkg::DATA_BITS-1:0]  csr_data,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [SAMPLE_BITS-1:0]   req_sample_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]   rsp_peak,
   output logic [mp2d_pkg::CH_BITS-1:0]    rsp_out_channel,
   output logic [mp2d_pkg::POS_BITS-1:0]   rsp_out_row,
   output logic [mp2d_pkg::POS_BITS-1:0]   rsp_out_col,
   output logic                            rsp_last_of_tensor
);

   mp2d_pkg::ctrl_cmd_type  cmd;
   mp2d_pkg::ctrl_stat_type stat;

   assign csr_ready = 1'b1;

   mp2d_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mp2d_dp #(
      .MAX_KERNEL  (MAX_KERNEL),
      .MAX_WIDTH   (MAX_WIDTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_sample_value   (req_sample_value),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_peak           (rsp_peak),
      .rsp_out_channel    (rsp_out_channel),
      .rsp_out_row        (rsp_out_row),
      .rsp_out_col        (rsp_out_col),
      .rsp_last_of_tensor (rsp_last_of_tensor)
   );

endmodule
